// ===== rtl/core/epdu_pkg.sv =====
// ----------------------------------------------------------------------------
// epdu_pkg
// Shared types and codes of the edge probe decision unit.
// ----------------------------------------------------------------------------
package epdu_pkg;

  localparam int unsigned WinW          = 10;
  localparam int unsigned WordW         = 32;
  localparam int unsigned DefWorkHeight = 4;
  localparam int unsigned DefSubHeight  = 64;

  // fixed-point scale used for division by a constant height
  localparam int unsigned RecipShift = 20;
  localparam int unsigned RecipW     = RecipShift + 1;

  typedef enum logic {
    MODE_FIND   = 1'b0,
    MODE_INSERT = 1'b1
  } mode_e;

  // find outcome codes
  localparam logic [1:0] FO_NOT_STOPPED = 2'd0;
  localparam logic [1:0] FO_NOT_FOUND   = 2'd1;
  localparam logic [1:0] FO_FOUND       = 2'd2;

  // insert exit codes
  localparam logic [1:0] IE_SWAPPED     = 2'd0;
  localparam logic [1:0] IE_LOADED      = 2'd1;
  localparam logic [1:0] IE_UPDATED     = 2'd2;
  localparam logic [1:0] IE_PASSED      = 2'd3;

  // interval verdict codes
  localparam logic [1:0] IV_FIRST_GEN   = 2'd0;
  localparam logic [1:0] IV_LOWER_GEN   = 2'd1;
  localparam logic [1:0] IV_CURRENT_GEN = 2'd2;
  localparam logic [1:0] IV_QUIT        = 2'd3;

  // calculation unit commands
  localparam logic [2:0] CAL_NONE       = 3'd0;
  localparam logic [2:0] CAL_INSERT     = 3'd1;
  localparam logic [2:0] CAL_UPDATE     = 3'd2;
  localparam logic [2:0] CAL_UPDATE_PTR = 3'd3;
  localparam logic [2:0] CAL_DELETE     = 3'd4;
  localparam logic [2:0] CAL_DEL_CRUMPLE = 3'd5;

  // crumple-in verdicts
  localparam logic [1:0] CR_NONE        = 2'd0;
  localparam logic [1:0] CR_QUIT        = 2'd1;
  localparam logic [1:0] CR_CRUMPLE     = 2'd2;

  typedef struct packed {
    logic             first_of_edge;
    logic             delete_edge;
    logic [1:0]       find_outcome;
    logic [1:0]       insert_exit;
    logic             is_clustered;
    logic [WordW-1:0] edge_block_base;
    logic [WinW-1:0]  sub_top;
    logic [WinW-1:0]  sub_bottom;
    logic [WinW-1:0]  start_top;
    logic [WordW-1:0] neighbor_id;
    logic [WordW-1:0] link_weight;
  } item_t;

  typedef struct packed {
    mode_e            next_mode;
    logic             writeback_enable;
    logic [WordW-1:0] writeback_addr;
    logic [WinW-1:0]  subblock_index;
    logic             mark_clustered;
    logic [1:0]       interval_verdict;
    logic [2:0]       cal_cmd;
    logic [1:0]       crumple_verdict;
    logic [WordW-1:0] neighbor_out;
    logic [WordW-1:0] weight_out;
    logic [WinW-1:0]  window_top;
    logic             fault;
  } result_t;

  typedef struct packed {
    mode_e           mode;
    logic [WinW-1:0] top;
    logic [WinW-1:0] bottom;
    logic            rolled;
  } state_t;

endpackage

// ===== rtl/core/epdu_decide.sv =====
// ----------------------------------------------------------------------------
// epdu_decide
// Combinational decision for one probe iteration: next mode, writeback,
// verdicts, commands and the next window state.
// ----------------------------------------------------------------------------
module epdu_decide
  import epdu_pkg::*;
#(
  parameter int unsigned WORK_HEIGHT = DefWorkHeight,
  parameter int unsigned SUB_HEIGHT  = DefSubHeight
) (
  input  item_t   item_i,
  input  state_t  state_i,
  input  logic    crumple_en_i,
  output result_t result_o,
  output state_t  state_o
);

  localparam logic [RecipW-1:0] WorkRecip =
    RecipW'(((2 ** RecipShift) + WORK_HEIGHT - 1) / WORK_HEIGHT);
  localparam logic [RecipW-1:0] SubRecip =
    RecipW'(((2 ** RecipShift) + SUB_HEIGHT - 1) / SUB_HEIGHT);
  localparam int unsigned ProdW = WinW + RecipW;
  localparam logic [WinW-1:0] WorkStep = WinW'(WORK_HEIGHT);
  localparam logic [WinW-1:0] WorkSpan = WinW'(WORK_HEIGHT - 1);

  state_t           eff;
  logic [ProdW-1:0] top_prod;
  logic [ProdW-1:0] sub_prod;
  logic             last;
  logic             advance;
  mode_e            nmode;
  logic             wb;
  logic             mark;
  logic [1:0]       verdict;
  logic [2:0]       cal;
  logic [1:0]       crum;
  logic             fault;
  state_t           nxt;

  // reload on first request of an edge
  always_comb begin
    eff = state_i;
    if (item_i.first_of_edge) begin
      eff.mode   = MODE_FIND;
      eff.top    = item_i.start_top;
      eff.bottom = item_i.start_top + WorkSpan;
      eff.rolled = 1'b0;
    end
  end

  // division by constant height via reciprocal multiply, exact for 10-bit values
  assign top_prod = ProdW'(eff.top) * ProdW'(WorkRecip);
  assign sub_prod = ProdW'(item_i.sub_top) * ProdW'(SubRecip);

  assign last = eff.rolled && (eff.top == item_i.start_top);

  always_comb begin
    nmode   = eff.mode;
    wb      = 1'b0;
    mark    = 1'b0;
    verdict = IV_FIRST_GEN;
    cal     = CAL_NONE;
    crum    = CR_NONE;
    fault   = 1'b0;
    advance = 1'b0;
    unique case (eff.mode)
      MODE_FIND: begin
        unique case (item_i.find_outcome)
          FO_NOT_FOUND: begin
            verdict = IV_QUIT;
            if (!item_i.delete_edge) begin
              nmode   = MODE_INSERT;
              verdict = IV_FIRST_GEN;
              cal     = CAL_INSERT;
            end else if (crumple_en_i) begin
              crum = CR_QUIT;
            end
          end
          FO_FOUND: begin
            wb      = 1'b1;
            verdict = IV_QUIT;
            if (!item_i.delete_edge) begin
              cal = CAL_UPDATE;
            end else if (crumple_en_i) begin
              cal  = CAL_DEL_CRUMPLE;
              crum = item_i.is_clustered ? CR_CRUMPLE : CR_QUIT;
            end else begin
              cal = CAL_DELETE;
            end
          end
          FO_NOT_STOPPED: begin
            if (last) begin
              mark    = !item_i.is_clustered;
              verdict = IV_LOWER_GEN;
            end else begin
              verdict = IV_CURRENT_GEN;
              advance = 1'b1;
            end
          end
          default: begin
            fault = 1'b1;
          end
        endcase
      end
      MODE_INSERT: begin
        unique case (item_i.insert_exit)
          IE_LOADED: begin
            nmode   = MODE_FIND;
            wb      = 1'b1;
            verdict = IV_QUIT;
            cal     = CAL_UPDATE_PTR;
          end
          IE_UPDATED: begin
            nmode   = MODE_FIND;
            wb      = 1'b1;
            verdict = IV_QUIT;
          end
          IE_SWAPPED, IE_PASSED: begin
            wb = (item_i.insert_exit == IE_SWAPPED);
            if (last) begin
              mark    = !item_i.is_clustered;
              verdict = IV_LOWER_GEN;
            end else begin
              verdict = IV_CURRENT_GEN;
              advance = 1'b1;
            end
          end
          default: begin
            fault = 1'b1;
          end
        endcase
      end
      default: begin
        fault = 1'b1;
      end
    endcase
  end

  // window step: next work block, or wrap to sub-block top
  always_comb begin
    nxt      = eff;
    nxt.mode = nmode;
    if (advance) begin
      if (eff.bottom == item_i.sub_bottom) begin
        nxt.top    = item_i.sub_top;
        nxt.bottom = item_i.sub_top + WorkSpan;
        nxt.rolled = 1'b1;
      end else begin
        nxt.top    = eff.top + WorkStep;
        nxt.bottom = eff.bottom + WorkStep;
      end
    end
  end

  assign state_o = nxt;

  always_comb begin
    result_o.next_mode        = nmode;
    result_o.writeback_enable = wb;
    result_o.writeback_addr   = item_i.edge_block_base
                                + WordW'(top_prod[RecipShift +: WinW]);
    result_o.subblock_index   = sub_prod[RecipShift +: WinW];
    result_o.mark_clustered   = mark;
    result_o.interval_verdict = verdict;
    result_o.cal_cmd          = cal;
    result_o.crumple_verdict  = crum;
    result_o.neighbor_out     = item_i.neighbor_id;
    result_o.weight_out       = item_i.link_weight;
    result_o.window_top       = nxt.top;
    result_o.fault            = fault;
  end

endmodule

// ===== rtl/core/epdu_state.sv =====
// ----------------------------------------------------------------------------
// epdu_state
// Mode, work-block window and rollover registers, updated once per request.
// ----------------------------------------------------------------------------
module epdu_state
  import epdu_pkg::*;
#(
  parameter int unsigned WORK_HEIGHT = DefWorkHeight
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   update_i,
  input  state_t state_d,
  output state_t state_o
);

  state_t state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode   <= MODE_FIND;
      state_q.top    <= '0;
      state_q.bottom <= WinW'(WORK_HEIGHT - 1);
      state_q.rolled <= 1'b0;
    end else if (update_i) begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

`ifndef SYNTHESIS
  // window always spans one work block
  a_window_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.bottom - state_q.top) == WinW'(WORK_HEIGHT - 1))
    else $error("window span broken");

  // rollover only sets on an update
  a_roll_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q.rolled) |-> $past(update_i))
    else $error("rollover set without update");
`endif

endmodule

// ===== rtl/core/edge_probe_decision_unit.sv =====
// ----------------------------------------------------------------------------
// edge_probe_decision_unit
// Per probe iteration decision of the edge-block update engine.
// ----------------------------------------------------------------------------
// path: input register, then decision logic into the result register
// throughput: one request per cycle while the output is not stalled, set by
// the combinational decision path
// reset: mode find, window 0 .. WORK_HEIGHT-1, rollover clear, crumple-in off,
// both register stages empty
module edge_probe_decision_unit
  import epdu_pkg::*;
#(
  parameter int unsigned WORK_HEIGHT = DefWorkHeight,
  parameter int unsigned SUB_HEIGHT  = DefSubHeight
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             first_of_edge_i,
  input  logic             delete_edge_i,
  input  logic [1:0]       find_outcome_i,
  input  logic [1:0]       insert_exit_i,
  input  logic             is_clustered_i,
  input  logic [WordW-1:0] edge_block_base_i,
  input  logic [WinW-1:0]  sub_top_i,
  input  logic [WinW-1:0]  sub_bottom_i,
  input  logic [WinW-1:0]  start_top_i,
  input  logic [WordW-1:0] neighbor_id_i,
  input  logic [WordW-1:0] link_weight_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             next_mode_o,
  output logic             writeback_enable_o,
  output logic [WordW-1:0] writeback_addr_o,
  output logic [WinW-1:0]  subblock_index_o,
  output logic             mark_clustered_o,
  output logic [1:0]       interval_verdict_o,
  output logic [2:0]       cal_cmd_o,
  output logic [1:0]       crumple_verdict_o,
  output logic [WordW-1:0] neighbor_out_o,
  output logic [WordW-1:0] weight_out_o,
  output logic [WinW-1:0]  window_top_o,
  output logic             fault_o
);

  logic    crumple_q;
  logic    in_valid_q;
  item_t   item_q;
  logic    out_valid_q;
  logic    out_valid_d;
  result_t res_q;
  result_t res_d;
  state_t  state;
  state_t  state_d;
  logic    fire;
  logic    in_take;

  // request moves from input register to result register
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;
  assign in_take    = in_valid_i && in_ready_o;
  assign out_valid_d = fire || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crumple_q <= 1'b0;
    end else if (cfg_we_i) begin
      crumple_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.first_of_edge   <= first_of_edge_i;
      item_q.delete_edge     <= delete_edge_i;
      item_q.find_outcome    <= find_outcome_i;
      item_q.insert_exit     <= insert_exit_i;
      item_q.is_clustered    <= is_clustered_i;
      item_q.edge_block_base <= edge_block_base_i;
      item_q.sub_top         <= sub_top_i;
      item_q.sub_bottom      <= sub_bottom_i;
      item_q.start_top       <= start_top_i;
      item_q.neighbor_id     <= neighbor_id_i;
      item_q.link_weight     <= link_weight_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  epdu_decide #(
    .WORK_HEIGHT (WORK_HEIGHT),
    .SUB_HEIGHT  (SUB_HEIGHT)
  ) u_decide (
    .item_i       (item_q),
    .state_i      (state),
    .crumple_en_i (crumple_q),
    .result_o     (res_d),
    .state_o      (state_d)
  );

  epdu_state #(
    .WORK_HEIGHT (WORK_HEIGHT)
  ) u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (fire),
    .state_d  (state_d),
    .state_o  (state)
  );

  assign out_valid_o        = out_valid_q;
  assign next_mode_o        = res_q.next_mode;
  assign writeback_enable_o = res_q.writeback_enable;
  assign writeback_addr_o   = res_q.writeback_addr;
  assign subblock_index_o   = res_q.subblock_index;
  assign mark_clustered_o   = res_q.mark_clustered;
  assign interval_verdict_o = res_q.interval_verdict;
  assign cal_cmd_o          = res_q.cal_cmd;
  assign crumple_verdict_o  = res_q.crumple_verdict;
  assign neighbor_out_o     = res_q.neighbor_out;
  assign weight_out_o       = res_q.weight_out;
  assign window_top_o       = res_q.window_top;
  assign fault_o            = res_q.fault;

`ifndef SYNTHESIS
  // a faulted request commands nothing
  a_fault_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fault_o) |-> (!writeback_enable_o && (cal_cmd_o == CAL_NONE)
      && (interval_verdict_o == IV_FIRST_GEN)))
    else $error("fault with active command");

  // crumple verdict only ends a find
  a_crumple_find: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (crumple_verdict_o != CR_NONE)) |->
      ((next_mode_o == MODE_FIND) && (interval_verdict_o == IV_QUIT)))
    else $error("crumple verdict outside find quit");

  // a full pipe with a stalled output takes no new request
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("request taken into full pipe");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(res_q)))
    else $error("stalled result changed");
`endif

endmodule

// ===== sim/edge_probe_decision_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edge_probe_decision_checker
// Watches the request and result channels of the edge probe decision unit,
// keeps its own copy of mode, work-block window and rollover, predicts the
// decision of every accepted request and compares each accepted result field
// by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module edge_probe_decision_checker
  import epdu_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cfg_we_i,
  input  logic    cfg_data_i,
  input  logic    in_valid_i,
  input  logic    in_ready_i,
  input  item_t   probe_i,
  input  logic    out_valid_i,
  input  logic    out_ready_i,
  input  result_t result_i,
  output int      fail_count_o,
  output int      outstanding_o
);

  localparam int unsigned WorkH     = DefWorkHeight;
  localparam int unsigned SubH      = DefSubHeight;

  state_t  probe_st;
  logic    crumple_en;
  result_t decision_q[$];
  result_t want;

  function automatic result_t decide_probe(input item_t it);
    result_t r;
    mode_e   nmode;
    logic    last;
    logic    advance;
    r       = '0;
    advance = 1'b0;
    if (it.first_of_edge) begin
      probe_st.mode   = MODE_FIND;
      probe_st.top    = it.start_top;
      probe_st.bottom = it.start_top + WinW'(WorkH - 1);
      probe_st.rolled = 1'b0;
    end
    // address uses the window before any advance
    r.writeback_addr = it.edge_block_base + probe_st.top / WorkH;
    r.subblock_index = WinW'(it.sub_top / SubH);
    last  = probe_st.rolled && (probe_st.top == it.start_top);
    nmode = probe_st.mode;
    if (probe_st.mode == MODE_FIND) begin
      case (it.find_outcome)
        FO_NOT_FOUND: begin
          r.interval_verdict = IV_QUIT;
          if (!it.delete_edge) begin
            nmode              = MODE_INSERT;
            r.interval_verdict = IV_FIRST_GEN;
            r.cal_cmd          = CAL_INSERT;
          end else if (crumple_en) begin
            r.crumple_verdict = CR_QUIT;
          end
        end
        FO_FOUND: begin
          r.writeback_enable = 1'b1;
          r.interval_verdict = IV_QUIT;
          if (!it.delete_edge) begin
            r.cal_cmd = CAL_UPDATE;
          end else if (crumple_en) begin
            r.cal_cmd         = CAL_DEL_CRUMPLE;
            r.crumple_verdict = it.is_clustered ? CR_CRUMPLE : CR_QUIT;
          end else begin
            r.cal_cmd = CAL_DELETE;
          end
        end
        FO_NOT_STOPPED: begin
          if (last) begin
            r.mark_clustered   = !it.is_clustered;
            r.interval_verdict = IV_LOWER_GEN;
          end else begin
            r.interval_verdict = IV_CURRENT_GEN;
            advance            = 1'b1;
          end
        end
        default: r.fault = 1'b1;
      endcase
    end else begin
      case (it.insert_exit)
        IE_LOADED: begin
          nmode              = MODE_FIND;
          r.writeback_enable = 1'b1;
          r.interval_verdict = IV_QUIT;
          r.cal_cmd          = CAL_UPDATE_PTR;
        end
        IE_UPDATED: begin
          nmode              = MODE_FIND;
          r.writeback_enable = 1'b1;
          r.interval_verdict = IV_QUIT;
        end
        default: begin
          r.writeback_enable = (it.insert_exit == IE_SWAPPED);
          if (last) begin
            r.mark_clustered   = !it.is_clustered;
            r.interval_verdict = IV_LOWER_GEN;
          end else begin
            r.interval_verdict = IV_CURRENT_GEN;
            advance            = 1'b1;
          end
        end
      endcase
    end
    if (advance) begin
      if (probe_st.bottom == it.sub_bottom) begin
        // wrap to the sub-block top
        probe_st.top    = it.sub_top;
        probe_st.bottom = it.sub_top + WinW'(WorkH - 1);
        probe_st.rolled = 1'b1;
      end else begin
        probe_st.top    = probe_st.top + WinW'(WorkH);
        probe_st.bottom = probe_st.bottom + WinW'(WorkH);
      end
    end
    if (!r.fault) probe_st.mode = nmode;
    r.next_mode    = nmode;
    r.neighbor_out = it.neighbor_id;
    r.weight_out   = it.link_weight;
    r.window_top   = probe_st.top;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [WordW-1:0] exp_val,
                             input logic [WordW-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, exp_val, act_val);
      fail_count_o++;
    end
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_st      = '{mode: MODE_FIND, top: '0, bottom: WinW'(WorkH - 1), rolled: 1'b0};
      crumple_en    = 1'b0;
      decision_q.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (decision_q.size() == 0) begin
          $display("%0t ns: result with no request pending, expected none, actual 0x%0h",
                   $time, result_i);
          fail_count_o++;
        end else begin
          want = decision_q.pop_front();
          check_field("next_mode", want.next_mode, result_i.next_mode);
          check_field("writeback_enable", want.writeback_enable,
                      result_i.writeback_enable);
          check_field("writeback_addr", want.writeback_addr, result_i.writeback_addr);
          check_field("subblock_index", want.subblock_index, result_i.subblock_index);
          check_field("mark_clustered", want.mark_clustered, result_i.mark_clustered);
          check_field("interval_verdict", want.interval_verdict,
                      result_i.interval_verdict);
          check_field("cal_cmd", want.cal_cmd, result_i.cal_cmd);
          check_field("crumple_verdict", want.crumple_verdict, result_i.crumple_verdict);
          check_field("neighbor_out", want.neighbor_out, result_i.neighbor_out);
          check_field("weight_out", want.weight_out, result_i.weight_out);
          check_field("window_top", want.window_top, result_i.window_top);
          check_field("fault", want.fault, result_i.fault);
        end
      end
      if (cfg_we_i) crumple_en = cfg_data_i;
      if (in_valid_i && in_ready_i) decision_q.push_back(decide_probe(probe_i));
      outstanding_o <= decision_q.size();
    end
  end

endmodule

// ===== sim/edge_probe_decision_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edge_probe_decision_unit_tb
// Drives directed probe sequences and then random edge updates, mostly
// well-formed edges inside a sub-block with some noise, through several
// idle and stall mixes and both crumple-in settings; the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module edge_probe_decision_unit_tb;
  import epdu_pkg::*;

  typedef enum int {PR_NONE, PR_RX_HOLD, PR_TX_PAUSE} pressure_e;

  localparam logic [1:0] FO_UNKNOWN  = 2'd3;
  localparam int         PhaseItems  = 240;
  localparam int         HoldCycles  = 300;
  localparam int         StallLimit  = 4000;
  localparam int         DrainCycles = 4;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_data;
  logic             in_valid;
  logic             in_ready;
  logic             out_valid;
  logic             out_ready;
  item_t            probe_req;
  logic             next_mode;
  logic             wb_en;
  logic [WordW-1:0] wb_addr;
  logic [WinW-1:0]  sub_idx;
  logic             mark;
  logic [1:0]       verdict;
  logic [2:0]       cal;
  logic [1:0]       crumple;
  logic [WordW-1:0] nbr_out;
  logic [WordW-1:0] wgt_out;
  logic [WinW-1:0]  win_top;
  logic             fault;
  result_t          dut_result;

  int fail_count;
  int outstanding;
  int idle_pct;
  int rx_stall_pct;
  int hold_serial;
  int watchdog;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  edge_probe_decision_unit dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .first_of_edge_i    (probe_req.first_of_edge),
    .delete_edge_i      (probe_req.delete_edge),
    .find_outcome_i     (probe_req.find_outcome),
    .insert_exit_i      (probe_req.insert_exit),
    .is_clustered_i     (probe_req.is_clustered),
    .edge_block_base_i  (probe_req.edge_block_base),
    .sub_top_i          (probe_req.sub_top),
    .sub_bottom_i       (probe_req.sub_bottom),
    .start_top_i        (probe_req.start_top),
    .neighbor_id_i      (probe_req.neighbor_id),
    .link_weight_i      (probe_req.link_weight),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .next_mode_o        (next_mode),
    .writeback_enable_o (wb_en),
    .writeback_addr_o   (wb_addr),
    .subblock_index_o   (sub_idx),
    .mark_clustered_o   (mark),
    .interval_verdict_o (verdict),
    .cal_cmd_o          (cal),
    .crumple_verdict_o  (crumple),
    .neighbor_out_o     (nbr_out),
    .weight_out_o       (wgt_out),
    .window_top_o       (win_top),
    .fault_o            (fault)
  );

  assign dut_result = {next_mode, wb_en, wb_addr, sub_idx, mark, verdict, cal, crumple,
                       nbr_out, wgt_out, win_top, fault};

  edge_probe_decision_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .probe_i       (probe_req),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .result_i      (dut_result),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int served;
    served = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_serial != served) begin
        served = hold_serial;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      watchdog <= 0;
    end else if (watchdog >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      watchdog <= watchdog + 1;
    end
  end

  task automatic offer(input item_t it);
    probe_req <= it;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic probe(input logic first, input logic del, input logic [1:0] fo,
                       input logic [1:0] ie, input logic clus,
                       input logic [WordW-1:0] base, input logic [WinW-1:0] stop,
                       input logic [WinW-1:0] sbot, input logic [WinW-1:0] start);
    item_t it;
    it.first_of_edge   = first;
    it.delete_edge     = del;
    it.find_outcome    = fo;
    it.insert_exit     = ie;
    it.is_clustered    = clus;
    it.edge_block_base = base;
    it.sub_top         = stop;
    it.sub_bottom      = sbot;
    it.start_top       = start;
    it.neighbor_id     = $urandom;
    it.link_weight     = $urandom;
    offer(it);
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_cfg(input logic crumple_in);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= crumple_in;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic random_edges(input int n);
    int               sent;
    int               blocks;
    int               len;
    int               r;
    logic             del;
    logic [WinW-1:0]  stop;
    logic [WinW-1:0]  sbot;
    logic [WinW-1:0]  start;
    logic [WordW-1:0] base;
    logic [1:0]       fo;
    logic [1:0]       ie;
    sent = 0;
    while (sent < n) begin
      // small sub-blocks let the window roll over within a short edge
      blocks = $urandom_range(1) ? $urandom_range(1, 3) : $urandom_range(4, 16);
      stop   = WinW'($urandom_range(0, 15) * 64);
      sbot   = stop + WinW'(blocks * 4 - 1);
      start  = stop + WinW'($urandom_range(0, blocks - 1) * 4);
      base   = $urandom;
      del    = 1'($urandom_range(1));
      len    = $urandom_range(1, 2 * blocks + 4);
      for (int k = 0; k < len && sent < n; k++) begin
        if ($urandom_range(99) < 15) begin
          probe(1'($urandom_range(1)), 1'($urandom_range(1)), 2'($urandom), 2'($urandom),
                1'($urandom_range(1)), $urandom, WinW'($urandom), WinW'($urandom),
                WinW'($urandom));
        end else begin
          r  = $urandom_range(99);
          fo = (r < 80) ? FO_NOT_STOPPED : (r < 89) ? FO_NOT_FOUND :
               (r < 98) ? FO_FOUND : FO_UNKNOWN;
          r  = $urandom_range(99);
          ie = (r < 40) ? IE_SWAPPED : (r < 80) ? IE_PASSED :
               (r < 90) ? IE_LOADED : IE_UPDATED;
          probe(k == 0, del, fo, ie, 1'($urandom_range(1)), base, stop, sbot, start);
        end
        sent++;
      end
    end
  endtask

  task automatic run_phase(input logic crumple_in, input int tx_idle, input int rx_stall,
                           input pressure_e press);
    write_cfg(crumple_in);
    idle_pct     = tx_idle;
    rx_stall_pct <= rx_stall;
    random_edges(PhaseItems / 2);
    if (press == PR_RX_HOLD) hold_serial <= hold_serial + 1;
    if (press == PR_TX_PAUSE) drain();
    random_edges(PhaseItems - PhaseItems / 2);
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    probe_req    <= '0;
    cfg_we       <= 1'b0;
    cfg_data     <= 1'b0;
    hold_serial  <= 0;
    rx_stall_pct <= 0;
    idle_pct     = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    write_cfg(1'b0);
    // window wraps at once on the sub-block bottom, address wraps past 2^32
    probe(1, 0, FO_NOT_STOPPED, IE_PASSED, 0, '1, 10'd0, 10'd7, 10'd4);
    probe(0, 0, FO_NOT_STOPPED, IE_SWAPPED, 0, '1, 10'd0, 10'd7, 10'd4);
    // back at the start block after rollover: last work block
    probe(0, 0, FO_NOT_STOPPED, IE_SWAPPED, 0, '1, 10'd0, 10'd7, 10'd4);
    probe(0, 0, FO_NOT_STOPPED, IE_SWAPPED, 1, '1, 10'd0, 10'd7, 10'd4);
    probe(0, 0, FO_NOT_FOUND, IE_SWAPPED, 0, '1, 10'd0, 10'd7, 10'd4);
    probe(0, 0, FO_FOUND, IE_SWAPPED, 0, '1, 10'd0, 10'd7, 10'd4);
    probe(0, 0, FO_FOUND, IE_PASSED, 1, '1, 10'd0, 10'd7, 10'd0);
    probe(0, 0, FO_NOT_FOUND, IE_UPDATED, 0, '1, 10'd0, 10'd7, 10'd0);
    // window top advancing past 1023
    probe(1, 0, FO_NOT_FOUND, IE_LOADED, 0, '0, 10'd1023, 10'd1023, 10'd1020);
    probe(0, 0, FO_UNKNOWN, IE_SWAPPED, 1, '0, 10'd1023, 10'd5, 10'd1020);
    probe(0, 1, FO_NOT_STOPPED, IE_LOADED, 0, '0, 10'd1023, 10'd5, 10'd1020);
    probe(0, 1, FO_FOUND, IE_PASSED, 1, '0, 10'd1023, 10'd5, 10'd1020);
    probe(0, 0, FO_FOUND, IE_PASSED, 0, '0, 10'd1023, 10'd5, 10'd1020);
    probe(0, 1, FO_NOT_FOUND, IE_PASSED, 0, '0, 10'd1023, 10'd5, 10'd1020);
    // unknown find outcome in find mode
    probe(0, 0, FO_UNKNOWN, IE_PASSED, 0, '0, 10'd1023, 10'd5, 10'd1020);
    probe(1, 1, FO_UNKNOWN, IE_UPDATED, 1, '1, 10'd1023, 10'd0, 10'd1023);
    probe(0, 0, FO_NOT_STOPPED, IE_UPDATED, 1, '1, 10'd1023, 10'd0, 10'd1023);

    write_cfg(1'b1);
    probe(1, 1, FO_FOUND, IE_SWAPPED, 0, 32'h8000_0000, 10'd64, 10'd127, 10'd64);
    probe(1, 1, FO_FOUND, IE_SWAPPED, 1, 32'h8000_0000, 10'd64, 10'd127, 10'd64);
    probe(1, 1, FO_NOT_FOUND, IE_PASSED, 0, 32'h8000_0000, 10'd64, 10'd127, 10'd64);
    probe(1, 0, FO_FOUND, IE_PASSED, 1, 32'h8000_0000, 10'd64, 10'd127, 10'd64);
    probe(1, 0, FO_NOT_FOUND, IE_PASSED, 1, 32'h8000_0000, 10'd64, 10'd127, 10'd64);

    run_phase(1'b0, 0, 0, PR_NONE);
    run_phase(1'b1, 64, 0, PR_NONE);
    run_phase(1'b0, 0, 64, PR_NONE);
    run_phase(1'b1, 21, 21, PR_NONE);
    run_phase(1'b1, 0, 0, PR_RX_HOLD);
    run_phase(1'b0, 21, 21, PR_TX_PAUSE);
    drain();

    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/epdu_pkg.sv
rtl/core/epdu_decide.sv
rtl/core/epdu_state.sv
rtl/core/edge_probe_decision_unit.sv
sim/edge_probe_decision_checker.sv
sim/edge_probe_decision_unit_tb.sv
